// File: hdl/nsc_pkg.sv
package nsc_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam int          FIELD_W   = 5;
   localparam logic [FIELD_W-1:0] FIELD_MAX = 5'd31;

   // Widths of the stream payloads
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 3;

   // Sentence phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_BODY = 5'b00010,
      PH_HEX1 = 5'b00100,
      PH_HEX2 = 5'b01000,
      PH_TAIL = 5'b10000
   } phase_type;

   // One result item as it leaves the parser
   typedef struct packed {
      logic [7:0]         data_byte;
      logic [FIELD_W-1:0] field_number;
      logic               in_body;
      logic               field_end;
      logic               sentence_done;
      logic               checksum_ok;
   } result_type;

   // Hex digit value; bit 4 set when the byte is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h57)};
      end
      return v;
   endfunction

endpackage

// File: hdl/nsc_parse.sv
module nsc_parse
   import nsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] rx_byte,
   output result_type result
);

   phase_type          phase_ff,     phase_in;
   logic [7:0]         xor_ff,       xor_in;
   logic [7:0]         sum_ff,       sum_in;
   logic [FIELD_W-1:0] field_ff,     field_in;
   logic               hex_bad_ff,   hex_bad_in;

   logic [4:0]         digit;
   logic [3:0]         digit_val;
   logic [FIELD_W-1:0] field_next;

   // Decode the digit and the saturated field advance
   assign digit      = hex_value(rx_byte);
   assign digit_val  = digit[4] ? 4'h0 : digit[3:0];
   assign field_next = (field_ff != FIELD_MAX) ? field_ff + 5'd1 : field_ff;

   // Work out the result and the next state for this byte
   always_comb begin
      phase_in   = phase_ff;
      xor_in     = xor_ff;
      sum_in     = sum_ff;
      field_in   = field_ff;
      hex_bad_in = hex_bad_ff;
      result               = '0;
      result.data_byte     = rx_byte;

      if (rx_byte == CHAR_DOLLAR) begin
         // restart the sentence
         phase_in   = PH_BODY;
         xor_in     = '0;
         sum_in     = '0;
         field_in   = '0;
         hex_bad_in = 1'b0;
      end else begin
         case (phase_ff)
            PH_BODY: begin
               result.field_number = field_ff;
               if (rx_byte == CHAR_STAR) begin
                  result.field_end = 1'b1;
                  field_in         = field_next;
                  phase_in         = PH_HEX1;
               end else if (rx_byte == CHAR_CR) begin
                  result.sentence_done = 1'b1;
                  phase_in             = PH_IDLE;
               end else begin
                  result.in_body = 1'b1;
                  xor_in         = xor_ff ^ rx_byte;
                  if (rx_byte == CHAR_COMMA) begin
                     result.field_end = 1'b1;
                     field_in         = field_next;
                  end
               end
            end
            PH_HEX1, PH_HEX2, PH_TAIL: begin
               result.field_number = field_ff;
               if (rx_byte == CHAR_CR) begin
                  result.sentence_done = 1'b1;
                  result.checksum_ok   = (phase_ff == PH_TAIL) && !hex_bad_ff &&
                                         (sum_ff == xor_ff);
                  phase_in             = PH_IDLE;
               end else if (phase_ff == PH_TAIL) begin
                  hex_bad_in = 1'b1;
               end else begin
                  // shift in one checksum digit
                  sum_in = {sum_ff[3:0], digit_val};
                  if (digit[4]) begin
                     hex_bad_in = 1'b1;
                  end
                  phase_in = (phase_ff == PH_HEX1) ? PH_HEX2 : PH_TAIL;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Advance the state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         xor_ff     <= '0;
         sum_ff     <= '0;
         field_ff   <= '0;
         hex_bad_ff <= 1'b0;
      end else if (in_fire) begin
         phase_ff   <= phase_in;
         xor_ff     <= xor_in;
         sum_ff     <= sum_in;
         field_ff   <= field_in;
         hex_bad_ff <= hex_bad_in;
      end
   end

`ifndef ASSERT_OFF
   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      result.checksum_ok |-> result.sentence_done)
      else $error("checksum_ok without sentence_done");

   a_dollar_restarts: assert property (@(posedge clock) disable iff (reset)
      in_fire && rx_byte == CHAR_DOLLAR |=> phase_ff == PH_BODY && field_ff == '0 &&
                                            xor_ff == '0 && !hex_bad_ff)
      else $error("dollar did not restart the sentence");

   a_field_step: assert property (@(posedge clock) disable iff (reset)
      in_fire && result.field_end && field_ff != FIELD_MAX
      |=> field_ff == $past(field_ff) + 5'd1)
      else $error("field index did not advance on field end");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      in_fire && result.sentence_done |=> phase_ff == PH_IDLE)
      else $error("sentence end did not return to idle");
`endif

endmodule

// File: hdl/nsc_out_reg.sv
module nsc_out_reg
   import nsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;
   logic       in_fire;
   logic       out_free;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Control: the output register drains first, the skid stage catches a stalled transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds data while output register is empty");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      in_fire && !out_valid_ff |=> out_valid_ff && out_data_ff == $past(in_data))
      else $error("accepted item did not reach the output register");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && out_data_ff == $past(skid_data_ff))
      else $error("skid item not moved to output in order");
`endif

endmodule

// File: hdl/nmea_sentence_checker.sv
// NMEA 0183 sentence checker. Bytes of a received sentence enter on req_ and every byte comes
// back on rsp_ from the output register with its comma-separated field index, body and
// field-end flags; the carriage return that ends a sentence raises rsp_tlast and reports in
// rsp_tuser[2] whether the two hex checksum digits after the asterisk matched the XOR of
// the body. A dollar sign anywhere restarts the sentence. One byte is taken every cycle
// while req_tready is high: the parser state updates once per byte, and a two-entry output
// register with a skid stage keeps req_tready high while one finished result waits on
// rsp_tready; a second waiting result drops it. No clearing pass follows reset.
module nmea_sentence_checker
   import nsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [12:8] field_number, zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] in_body, [1] field_end, [2] checksum_ok
   output logic                  rsp_tlast    // sentence_done
);

   result_type parse_result;
   result_type out_result;
   logic       in_fire;

   assign in_fire = req_tvalid && req_tready;

   // Parse one byte per transfer
   nsc_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .rx_byte (req_tdata[7:0]),
      .result  (parse_result)
   );

   // Hold results until the downstream side takes them
   nsc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   // Pack the result fields
   assign rsp_tdata = {3'b000, out_result.field_number, out_result.data_byte};
   assign rsp_tuser = {out_result.checksum_ok, out_result.field_end, out_result.in_body};
   assign rsp_tlast = out_result.sentence_done;

endmodule
